// ===== src/vector_magnitude_difference_gradient_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_DIFFERENCE_GRADIENT_ASSERT_SVH
`define VECTOR_MAGNITUDE_DIFFERENCE_GRADIENT_ASSERT_SVH

// same-cycle implication
`define VMDG_ASSERT_IMP(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define VMDG_ASSERT_NXT(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) else $error(msg);

`endif

// ===== src/vmdg_pkg.sv =====
// ----------------------------------------------------------------------------
// vmdg_pkg
// Widths, latencies and shared types of the norm difference / gradient block.
// ----------------------------------------------------------------------------
package vmdg_pkg;

   localparam int CW  = 32;          // component width
   localparam int FB  = 16;          // fraction bits
   localparam int NW  = CW + 1;      // norm width
   localparam int SQW = 2 * NW;      // sum of squares width
   localparam int DW  = 33;          // norm difference width
   localparam int GW  = 18;          // gradient width
   localparam int QW  = FB + 1;      // unit quotient width

   localparam int NORM_LAT = NW + 4;
   localparam int UNIT_LAT = FB + 2;

   localparam int REQ_DATA_W = 6 * CW;
   localparam int RSP_BITS   = DW + 6 * GW;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   typedef struct packed {
      logic [2:0]         neg;
      logic [2:0][CW-1:0] mag;
   } vmdg_vec_type;

   typedef struct packed {
      logic               second_norm_zero;
      logic               first_norm_zero;
      logic [2:0][GW-1:0] grad_second;
      logic [2:0][GW-1:0] grad_first;
      logic [DW-1:0]      norm_difference;
   } vmdg_result_type;

endpackage

// ===== src/vector_magnitude_difference_gradient.sv =====
// ----------------------------------------------------------------------------
// vector_magnitude_difference_gradient
// Norm difference of two Q15.16 3-vectors and its unit-vector gradients.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one word carries both vectors, first x/y/z then second x/y/z,
//   32 bits each, signed Q15.16.
//   rsp_ channel: one word per request word, in order. tdata holds the norm
//   difference (33 bits) and the six Q1.16 gradient components (18 bits each);
//   tuser holds the two zero-norm flags.
//   The delay from an accepted request to rsp_tvalid is set by the
//   33-stage square root (one root bit per stage) and the 18-stage dividers.
//   Throughput: one word per cycle while rsp_tready stays high.
//   A stalled rsp_tready first fills a one-word skid stage behind the output
//   register; only then does req_tready drop and the whole pipeline hold.
//   Nothing is lost or repeated across a stall.
//   Reset clears all valid bits; no state survives between words.
// ----------------------------------------------------------------------------
`include "vector_magnitude_difference_gradient_assert.svh"

module vector_magnitude_difference_gradient (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [vmdg_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // norm_difference, grad_first_x/y/z, grad_second_x/y/z, zero pad
   output logic [vmdg_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // first_norm_zero, second_norm_zero
   output logic [vmdg_pkg::RSP_USER_W-1:0]       rsp_tuser
);

   localparam int CW = vmdg_pkg::CW;
   localparam int NW = vmdg_pkg::NW;
   localparam int DW = vmdg_pkg::DW;
   localparam int GW = vmdg_pkg::GW;
   localparam int UL = vmdg_pkg::UNIT_LAT;

   typedef struct packed {
      logic          sz;
      logic          fz;
      logic [DW-1:0] diff;
   } dly_type;

   logic                      en;
   logic                      norm_valid_a, norm_valid_b;
   logic [NW-1:0]             norm_a, norm_b;
   vmdg_pkg::vmdg_vec_type    vec_a, vec_b;
   logic [5:0]                unit_valid;
   logic [2:0][GW-1:0]        grad_a, grad_b;
   logic [NW:0]               diff_wide;
   dly_type                   dly_in;
   dly_type                   dly_ff [UL];
   vmdg_pkg::vmdg_result_type res, rsp_res;

   vmdg_norm u_norm_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .comp      (req_tdata[3*CW-1:0]),
      .out_valid (norm_valid_a),
      .norm      (norm_a),
      .vec       (vec_a)
   );

   vmdg_norm u_norm_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .comp      (req_tdata[6*CW-1:3*CW]),
      .out_valid (norm_valid_b),
      .norm      (norm_b),
      .vec       (vec_b)
   );

   for (genvar i = 0; i < 3; i++) begin : g_unit
      vmdg_unit u_unit_a (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (norm_valid_a),
         .mag       (vec_a.mag[i]),
         .neg       (vec_a.neg[i]),
         .flip      (1'b0),
         .norm      (norm_a),
         .out_valid (unit_valid[i]),
         .grad      (grad_a[i])
      );
      vmdg_unit u_unit_b (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (norm_valid_b),
         .mag       (vec_b.mag[i]),
         .neg       (vec_b.neg[i]),
         .flip      (1'b1),
         .norm      (norm_b),
         .out_valid (unit_valid[3+i]),
         .grad      (grad_b[i])
      );
   end

   assign diff_wide   = {1'b0, norm_a} - {1'b0, norm_b};
   assign dly_in.diff = DW'($signed(diff_wide));
   assign dly_in.fz   = norm_a == '0;
   assign dly_in.sz   = norm_b == '0;

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= dly_in;
         for (int i = 1; i < UL; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign res.norm_difference  = dly_ff[UL-1].diff;
   assign res.first_norm_zero  = dly_ff[UL-1].fz;
   assign res.second_norm_zero = dly_ff[UL-1].sz;
   assign res.grad_first       = grad_a;
   assign res.grad_second      = grad_b;

   vmdg_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unit_valid[0]),
      .in_data   (res),
      .in_ready  (en),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign req_tready = en;
   assign rsp_tdata  = vmdg_pkg::RSP_DATA_W'({rsp_res.grad_second, rsp_res.grad_first,
                                              rsp_res.norm_difference});
   assign rsp_tuser  = {rsp_res.second_norm_zero, rsp_res.first_norm_zero};

   `VMDG_ASSERT_IMP(a_lanes_aligned, norm_valid_a != norm_valid_b, 1'b0, "norm lanes out of step")
   `VMDG_ASSERT_IMP(a_units_aligned, |unit_valid, &unit_valid, "divider lanes out of step")
   `VMDG_ASSERT_NXT(a_stall_holds, !en && !rsp_tready, !en && rsp_tvalid, "skid word lost in stall")
   `VMDG_ASSERT_IMP(a_zero_grad, rsp_tvalid && rsp_tuser[0], rsp_tdata[DW+3*GW-1:DW] == '0,
                    "nonzero gradient on zero norm")

endmodule

// ===== src/vmdg_norm.sv =====
// ----------------------------------------------------------------------------
// vmdg_norm
// Magnitudes, squares, sum and a one-bit-per-stage rounded square root.
// ----------------------------------------------------------------------------
module vmdg_norm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [2:0][vmdg_pkg::CW-1:0]         comp,
   output logic                                 out_valid,
   output logic [vmdg_pkg::NW-1:0]              norm,
   output vmdg_pkg::vmdg_vec_type               vec
);

   localparam int LAT = vmdg_pkg::NORM_LAT;
   localparam int NW  = vmdg_pkg::NW;
   localparam int SQW = vmdg_pkg::SQW;
   localparam int CW  = vmdg_pkg::CW;

   logic [LAT-1:0] vld_ff, vld_in;

   vmdg_pkg::vmdg_vec_type vec_in, vec_a_ff, vec_b_ff, vec_c_ff, vec_o_ff;
   logic [2:0][2*CW-1:0]   sq_b_ff;
   logic [SQW-1:0]         sum_c_ff;
   logic [NW-1:0]          norm_ff;

   logic [SQW-1:0]         rem_ff  [NW];
   logic [NW-1:0]          root_ff [NW];
   vmdg_pkg::vmdg_vec_type vr_ff   [NW];

   assign vld_in = {vld_ff[LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec_in.neg[i] = comp[i][CW-1];
         vec_in.mag[i] = comp[i][CW-1] ? CW'(-comp[i]) : comp[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_a_ff <= vec_in;
         for (int i = 0; i < 3; i++) begin
            sq_b_ff[i] <= vec_a_ff.mag[i] * vec_a_ff.mag[i];
         end
         vec_b_ff <= vec_a_ff;
         sum_c_ff <= SQW'(sq_b_ff[0]) + SQW'(sq_b_ff[1]) + SQW'(sq_b_ff[2]);
         vec_c_ff <= vec_b_ff;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_root
      localparam int B = NW - 1 - k;
      logic [SQW-1:0]         rem_prev, trial;
      logic [NW-1:0]          root_prev;
      vmdg_pkg::vmdg_vec_type v_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = sum_c_ff;
         assign root_prev = '0;
         assign v_prev    = vec_c_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign v_prev    = vr_ff[k-1];
      end

      // (r + 2^b)^2 - r^2
      assign trial = (SQW'(root_prev) << (B + 1)) | (SQW'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_prev >= trial) begin
               rem_ff[k]  <= rem_prev - trial;
               root_ff[k] <= root_prev | (NW'(1) << B);
            end else begin
               rem_ff[k]  <= rem_prev;
               root_ff[k] <= root_prev;
            end
            vr_ff[k] <= v_prev;
         end
      end
   end

   // round to nearest: up when remainder exceeds root
   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff  <= (rem_ff[NW-1] > SQW'(root_ff[NW-1])) ? root_ff[NW-1] + NW'(1)
                                                          : root_ff[NW-1];
         vec_o_ff <= vr_ff[NW-1];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign norm      = norm_ff;
   assign vec       = vec_o_ff;

endmodule

// ===== src/vmdg_unit.sv =====
// ----------------------------------------------------------------------------
// vmdg_unit
// Pipelined restoring divider: signed unit component |c| * 2^FB / norm.
// ----------------------------------------------------------------------------
module vmdg_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [vmdg_pkg::CW-1:0]      mag,
   input  logic                         neg,
   input  logic                         flip,
   input  logic [vmdg_pkg::NW-1:0]      norm,
   output logic                         out_valid,
   output logic [vmdg_pkg::GW-1:0]      grad
);

   localparam int FB  = vmdg_pkg::FB;
   localparam int NW  = vmdg_pkg::NW;
   localparam int QW  = vmdg_pkg::QW;
   localparam int GW  = vmdg_pkg::GW;
   localparam int LAT = vmdg_pkg::UNIT_LAT;

   logic [LAT-1:0] vld_ff, vld_in;

   logic [NW-1:0] r_ff [FB+1];
   logic [QW-1:0] q_ff [FB+1];
   logic [NW-1:0] n_ff [FB+1];
   logic          s_ff [FB+1];
   logic [GW-1:0] grad_ff;

   logic [NW-1:0] mag_ext;
   logic          q0;
   logic [NW:0]   r_fin;
   logic          up_fin;
   logic [QW-1:0] q_fin;
   logic [GW-1:0] m_fin;

   assign vld_in = {vld_ff[LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign mag_ext = NW'(mag);
   assign q0      = mag_ext >= norm;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= q0 ? mag_ext - norm : mag_ext;
         q_ff[0] <= QW'(q0);
         n_ff[0] <= norm;
         s_ff[0] <= neg ^ flip;
      end
   end

   for (genvar k = 1; k <= FB; k++) begin : g_step
      logic [NW:0] r2;
      logic        ge;
      assign r2 = {r_ff[k-1], 1'b0};
      assign ge = r2 >= {1'b0, n_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= ge ? NW'(r2 - {1'b0, n_ff[k-1]}) : NW'(r2);
            q_ff[k] <= {q_ff[k-1][QW-2:0], ge};
            n_ff[k] <= n_ff[k-1];
            s_ff[k] <= s_ff[k-1];
         end
      end
   end

   assign r_fin  = {r_ff[FB], 1'b0};
   assign up_fin = r_fin >= {1'b0, n_ff[FB]};
   assign q_fin  = q_ff[FB] + QW'(up_fin);
   assign m_fin  = GW'(q_fin);

   always_ff @(posedge clock) begin
      if (en) begin
         if (n_ff[FB] == '0) begin
            grad_ff <= '0;
         end else begin
            grad_ff <= s_ff[FB] ? -m_fin : m_fin;
         end
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign grad      = grad_ff;

endmodule

// ===== src/vmdg_skid.sv =====
// ----------------------------------------------------------------------------
// vmdg_skid
// Output register with one skid word; stalls the pipeline only when full.
// ----------------------------------------------------------------------------
module vmdg_skid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  vmdg_pkg::vmdg_result_type   in_data,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output vmdg_pkg::vmdg_result_type   out_data
);

   logic                      out_valid_ff, skid_valid_ff;
   vmdg_pkg::vmdg_result_type out_ff, skid_ff;
   logic                      take_in, drain;

   assign in_ready = !skid_valid_ff;
   assign take_in  = in_ready && in_valid;
   assign drain    = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (drain) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (take_in) begin
            if (!out_valid_ff || drain) begin
               out_ff       <= in_data;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= in_data;
               skid_valid_ff <= 1'b1;
            end
         end else if (drain) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
